// ===== rtl/nhq_pkg.sv =====
package nhq_pkg;

    // Field widths
    localparam int WORD_BITS = 24;
    localparam logic [WORD_BITS-1:0] WORD_MAX = '1;

    // Configuration port
    localparam int ADDR_BITS = 3;
    localparam logic [0:0] REG_ICE_SG = 1'b0;
    localparam logic [0:0] REG_MIN_DEPTH = 1'b1;
    localparam logic [15:0] ICE_SG_RESET = 16'd60293;
    localparam logic [23:0] MIN_DEPTH_RESET = 24'd655;

    // Arithmetic constants
    localparam logic [19:0] G_Q16 = 20'd642646;
    localparam logic [20:0] K25LN2_Q20 = 21'd1817043;
    localparam logic [16:0] ICE_ROUND = 17'd32768;
    localparam logic [19:0] Q20_ROUND = 20'd524288;
    localparam logic [3:0] C_12 = 4'd12;
    localparam logic [13:0] C_12000 = 14'd12000;
    localparam logic [14:0] C_30000 = 15'd30000;
    localparam logic [11:0] C_2718 = 12'd2718;

    // Pipeline map (stage index that produces each value)
    localparam int ST_PROD = 1;
    localparam int ST_DIFF = 2;
    localparam int ST_SCALE = 3;
    localparam int ST_NORM = 4;
    localparam int SQ_FIRST = 4;
    localparam int SQ_STEPS = 24;
    localparam int G_FIRST = 4;
    localparam int G_STEPS = 22;
    localparam int LOG_FIRST = 5;
    localparam int LOG_STEPS = 20;
    localparam int T_FIRST = 4;
    localparam int T_STEPS = 38;
    localparam int ST_LPROD = 25;
    localparam int ST_DEN = 26;
    localparam int ST_VSET = 28;
    localparam int V_FIRST = 29;
    localparam int DIV_STEPS = 24;
    localparam int ST_VEL = 53;
    localparam int ST_FSET = 54;
    localparam int F_FIRST = 55;
    localparam int ST_LIN = 55;
    localparam int ST_OUT = 79;
    localparam int NUM_STAGES = 80;

    typedef struct packed {
        logic [15:0] ice_specific_gravity;
        logic [23:0] minimum_depth;
    } cfg_t;

    typedef struct packed {
        logic [23:0]        water_depth;
        logic signed [23:0] discharge_x;
        logic signed [23:0] discharge_y;
        logic [23:0]        ice_thickness;
        logic [23:0]        bed_roughness;
    } in_t;

    typedef struct packed {
        logic signed [24:0] effective_depth;
        logic [23:0]        velocity;
        logic [23:0]        froude_number;
        logic [23:0]        shear_velocity;
    } out_t;

endpackage

// ===== rtl/nhq_cfg.sv =====
module nhq_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nhq_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output nhq_pkg::cfg_t                 cfg
);
    import nhq_pkg::*;

    logic [15:0] sg_reg;
    logic [23:0] mind_reg;
    logic        wr_en;
    logic [0:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_reg   <= ICE_SG_RESET;
            mind_reg <= MIN_DEPTH_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ICE_SG:    sg_reg <= pwdata[15:0];
                REG_MIN_DEPTH: mind_reg <= pwdata[23:0];
                default:       ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_ICE_SG:    prdata = {16'd0, sg_reg};
            REG_MIN_DEPTH: prdata = {8'd0, mind_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.ice_specific_gravity = sg_reg;
    assign cfg.minimum_depth        = mind_reg;

endmodule

// ===== rtl/node_hydraulic_quantities_core.sv =====
// Node hydraulic quantities: one mesh node per request.
// Request channel: drive request and raise start; the request is taken at the
// rising edge where start is high and busy is low. busy is always low, so a
// new node may be started in every cycle.
// Result channel: done is high for exactly one cycle while result holds the
// effective depth, velocity, Froude number and shear velocity of one node.
// Results come back in request order.
// Each request is carried through stage registers 0 to 79; done is high while it is in the last.
// Throughput: one node per cycle. The 80 stages are set by the chain of
// bit-per-stage units: a 24-step square root for the discharge magnitude, a
// 24-step divide for velocity, then 24-step divides for Froude number and
// log-law shear velocity.
// Configuration: APB port, ice specific gravity at 0x0, minimum depth at 0x4.
// Write only while no node is in flight.
// Reset clears all stage valid bits and restores the register defaults;
// no clearing pass is needed. The receiver cannot stall: done is never held.
module node_hydraulic_quantities_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nhq_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  nhq_pkg::in_t                  request,
    output logic                          done,
    output nhq_pkg::out_t                 result
);
    import nhq_pkg::*;

    typedef struct packed {
        logic [23:0]        d;
        logic signed [23:0] qx;
        logic signed [23:0] qy;
        logic [23:0]        tice;
        logic [23:0]        ks;
        logic [39:0]        ice_p;
        logic [47:0]        ax2;
        logic [47:0]        ay2;
        logic [35:0]        ks2718;
        logic signed [24:0] h;
        logic [23:0]        hu;
        logic               wet;
        logic               lin;
        logic [27:0]        hu12;
        logic [37:0]        hu12000;
        logic [38:0]        t_den;
        logic [47:0]        m_rad;
        logic [24:0]        m_rem;
        logic [23:0]        m_root;
        logic [43:0]        g_rad;
        logic [22:0]        g_rem;
        logic [21:0]        g_root;
        logic [30:0]        la_y;
        logic [30:0]        lb_y;
        logic [24:0]        la_res;
        logic [24:0]        lb_res;
        logic [45:0]        l_prod;
        logic [26:0]        den;
        logic [38:0]        t_rem;
        logic [37:0]        t_low;
        logic [37:0]        t_q;
        logic               v_sat;
        logic [23:0]        v_rem;
        logic [23:0]        v_low;
        logic [23:0]        v_q;
        logic [23:0]        vel;
        logic               f_sat;
        logic [21:0]        f_rem;
        logic [23:0]        f_low;
        logic [23:0]        f_q;
        logic               u_sat;
        logic [26:0]        u_rem;
        logic [23:0]        u_low;
        logic [23:0]        u_q;
        logic [43:0]        p_lo;
        logic [41:0]        p_hi;
        logic [23:0]        us_lin;
        logic [23:0]        vel_o;
        logic [23:0]        fr_o;
        logic [23:0]        us_o;
    } work_t;

    cfg_t                  cfg;
    work_t                 stg_reg [NUM_STAGES];
    work_t                 stg_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;

    // Index of the leading one of a 28-bit value
    function automatic logic [4:0] msb_idx(input logic [27:0] x);
        logic [4:0] k;
        k = 5'd0;
        for (int i = 1; i < 28; i++)
        begin
            if (x[i])
                k = 5'(i);
        end
        return k;
    endfunction

    nhq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy = 1'b0;

    // Stage 0: capture the request
    always_comb
    begin
        stg_next[0]      = '0;
        stg_next[0].d    = request.water_depth;
        stg_next[0].qx   = request.discharge_x;
        stg_next[0].qy   = request.discharge_y;
        stg_next[0].tice = request.ice_thickness;
        stg_next[0].ks   = request.bed_roughness;
        vld_next[0]      = start & ~busy;
    end

    // Remaining stages
    for (genvar gi = 1; gi < NUM_STAGES; gi++)
    begin : g_stage
        localparam int LSH = (gi >= LOG_FIRST && gi < LOG_FIRST + LOG_STEPS) ?
                             (LOG_FIRST + LOG_STEPS - 1 - gi) : 0;

        always_comb
        begin : p_stage
            work_t       w;
            logic [23:0] ax, ay;
            logic [23:0] ice;
            logic [23:0] bk;
            logic [4:0]  k;
            logic [26:0] sr2, str;
            logic [24:0] gr2, gtr;
            logic [61:0] sqa, sqb;
            logic [25:0] lsub;
            logic [24:0] lpos;
            logic [46:0] dsum;
            logic [39:0] tr2;
            logic [24:0] vr2;
            logic [22:0] fr2;
            logic [27:0] ur2;
            logic [62:0] lsum;

            w     = stg_reg[gi-1];
            ax    = '0;
            ay    = '0;
            ice   = '0;
            bk    = '0;
            k     = '0;
            sr2   = '0;
            str   = '0;
            gr2   = '0;
            gtr   = '0;
            sqa   = '0;
            sqb   = '0;
            lsub  = '0;
            lpos  = '0;
            dsum  = '0;
            tr2   = '0;
            vr2   = '0;
            fr2   = '0;
            ur2   = '0;
            lsum  = '0;

            // Products: ice load, squared discharge, scaled roughness
            if (gi == ST_PROD)
            begin
                ax       = w.qx[23] ? 24'(~w.qx + 24'd1) : w.qx;
                ay       = w.qy[23] ? 24'(~w.qy + 24'd1) : w.qy;
                w.ice_p  = cfg.ice_specific_gravity * w.tice;
                w.ax2    = ax * ax;
                w.ay2    = ay * ay;
                w.ks2718 = C_2718 * w.ks;
            end

            // Effective depth and squared magnitude
            if (gi == ST_DIFF)
            begin
                ice      = 24'((41'(w.ice_p) + 41'(ICE_ROUND)) >> 16);
                w.h      = $signed({1'b0, w.d}) - $signed({1'b0, ice});
                w.m_rad  = w.ax2 + w.ay2;
                w.m_rem  = '0;
                w.m_root = '0;
            end

            // Depth scalings, wet test, roughness log setup, divide setup
            if (gi == ST_SCALE)
            begin
                w.hu      = w.h[23:0];
                w.wet     = w.h > $signed({1'b0, cfg.minimum_depth});
                w.hu12    = C_12 * w.hu;
                w.hu12000 = C_12000 * w.hu;
                w.t_den   = C_30000 * w.hu;
                w.g_rad   = G_Q16 * w.hu;
                w.g_rem   = '0;
                w.g_root  = '0;
                bk        = (w.ks == 24'd0) ? 24'd1 : w.ks;
                k         = msb_idx({4'd0, bk});
                w.lb_y    = 31'({7'd0, bk} << (5'd30 - k));
                w.lb_res  = {k, 20'd0};
                w.t_rem   = 39'(w.ks2718[35:22]);
                w.t_low   = {w.ks2718[21:0], 16'd0};
                w.t_q     = '0;
            end

            // Branch choice and depth log setup
            if (gi == ST_NORM)
            begin
                w.lin    = !(w.hu12000 > {2'd0, w.ks2718});
                k        = msb_idx(w.hu12);
                w.la_y   = 31'({3'd0, w.hu12} << (5'd30 - k));
                w.la_res = {k, 20'd0};
            end

            // Square root of the squared magnitude, two bits per stage
            if (gi >= SQ_FIRST && gi < SQ_FIRST + SQ_STEPS)
            begin
                sr2     = {w.m_rem, w.m_rad[47:46]};
                str     = {1'b0, w.m_root, 2'b01};
                w.m_rad = {w.m_rad[45:0], 2'b00};
                if (sr2 >= str)
                begin
                    w.m_rem  = 25'(sr2 - str);
                    w.m_root = {w.m_root[22:0], 1'b1};
                end
                else
                begin
                    w.m_rem  = sr2[24:0];
                    w.m_root = {w.m_root[22:0], 1'b0};
                end
            end

            // Square root of g*h
            if (gi >= G_FIRST && gi < G_FIRST + G_STEPS)
            begin
                gr2     = {w.g_rem, w.g_rad[43:42]};
                gtr     = {1'b0, w.g_root, 2'b01};
                w.g_rad = {w.g_rad[41:0], 2'b00};
                if (gr2 >= gtr)
                begin
                    w.g_rem  = 23'(gr2 - gtr);
                    w.g_root = {w.g_root[20:0], 1'b1};
                end
                else
                begin
                    w.g_rem  = gr2[22:0];
                    w.g_root = {w.g_root[20:0], 1'b0};
                end
            end

            // Log2 fraction bits by repeated squaring, both operands
            if (gi >= LOG_FIRST && gi < LOG_FIRST + LOG_STEPS)
            begin
                sqa = w.la_y * w.la_y;
                sqb = w.lb_y * w.lb_y;
                if (sqa[61])
                begin
                    w.la_y   = sqa[61:31];
                    w.la_res = w.la_res | (25'd1 << LSH);
                end
                else
                begin
                    w.la_y = sqa[60:30];
                end
                if (sqb[61])
                begin
                    w.lb_y   = sqb[61:31];
                    w.lb_res = w.lb_res | (25'd1 << LSH);
                end
                else
                begin
                    w.lb_y = sqb[60:30];
                end
            end

            // Log ratio times 2.5*ln2
            if (gi == ST_LPROD)
            begin
                lsub     = $signed({1'b0, w.la_res}) - $signed({1'b0, w.lb_res});
                lpos     = $signed(lsub) > 26'sd0 ? lsub[24:0] : 25'd0;
                w.l_prod = lpos * K25LN2_Q20;
            end

            // Round the log-law factor
            if (gi == ST_DEN)
            begin
                dsum  = 47'(w.l_prod) + 47'(Q20_ROUND);
                w.den = dsum[46:20];
            end

            // Linear-branch ratio t, one quotient bit per stage
            if (gi >= T_FIRST && gi < T_FIRST + T_STEPS)
            begin
                tr2     = {w.t_rem, w.t_low[37]};
                w.t_low = {w.t_low[36:0], 1'b0};
                if (tr2 >= {1'b0, w.t_den})
                begin
                    w.t_rem = 39'(tr2 - {1'b0, w.t_den});
                    w.t_q   = {w.t_q[36:0], 1'b1};
                end
                else
                begin
                    w.t_rem = tr2[38:0];
                    w.t_q   = {w.t_q[36:0], 1'b0};
                end
            end

            // Velocity divide setup with overflow check
            if (gi == ST_VSET)
            begin
                w.v_sat = {8'd0, w.m_root} >= {w.hu, 8'd0};
                w.v_rem = {8'd0, w.m_root[23:8]};
                w.v_low = {w.m_root[7:0], 16'd0};
                w.v_q   = '0;
            end

            if (gi >= V_FIRST && gi < V_FIRST + DIV_STEPS)
            begin
                vr2     = {w.v_rem, w.v_low[23]};
                w.v_low = {w.v_low[22:0], 1'b0};
                if (vr2 >= {1'b0, w.hu})
                begin
                    w.v_rem = 24'(vr2 - {1'b0, w.hu});
                    w.v_q   = {w.v_q[22:0], 1'b1};
                end
                else
                begin
                    w.v_rem = vr2[23:0];
                    w.v_q   = {w.v_q[22:0], 1'b0};
                end
            end

            if (gi == ST_VEL)
                w.vel = w.v_sat ? WORD_MAX : w.v_q;

            // Froude and log-law divide setup, linear-branch partial products
            if (gi == ST_FSET)
            begin
                w.f_sat = (w.g_root == 22'd0) || ({6'd0, w.vel} >= {w.g_root, 8'd0});
                w.f_rem = {6'd0, w.vel[23:8]};
                w.f_low = {w.vel[7:0], 16'd0};
                w.f_q   = '0;
                w.u_sat = (w.den == 27'd0) || ({7'd0, w.vel} >= {w.den, 4'd0});
                w.u_rem = {7'd0, w.vel[23:4]};
                w.u_low = {w.vel[3:0], 20'd0};
                w.u_q   = '0;
                w.p_lo  = w.vel * w.t_q[19:0];
                w.p_hi  = w.vel * w.t_q[37:20];
            end

            if (gi == ST_LIN)
            begin
                lsum     = {19'd0, w.p_lo} + {1'b0, w.p_hi, 20'd0};
                w.us_lin = (lsum[62:40] != 23'd0) ? WORD_MAX : lsum[39:16];
            end

            if (gi >= F_FIRST && gi < F_FIRST + DIV_STEPS)
            begin
                fr2     = {w.f_rem, w.f_low[23]};
                w.f_low = {w.f_low[22:0], 1'b0};
                if (fr2 >= {1'b0, w.g_root})
                begin
                    w.f_rem = 22'(fr2 - {1'b0, w.g_root});
                    w.f_q   = {w.f_q[22:0], 1'b1};
                end
                else
                begin
                    w.f_rem = fr2[21:0];
                    w.f_q   = {w.f_q[22:0], 1'b0};
                end
                ur2     = {w.u_rem, w.u_low[23]};
                w.u_low = {w.u_low[22:0], 1'b0};
                if (ur2 >= {1'b0, w.den})
                begin
                    w.u_rem = 27'(ur2 - {1'b0, w.den});
                    w.u_q   = {w.u_q[22:0], 1'b1};
                end
                else
                begin
                    w.u_rem = ur2[26:0];
                    w.u_q   = {w.u_q[22:0], 1'b0};
                end
            end

            // Final selection and dry gating
            if (gi == ST_OUT)
            begin
                w.vel_o = w.wet ? w.vel : 24'd0;
                w.fr_o  = !w.wet ? 24'd0 : (w.f_sat ? WORD_MAX : w.f_q);
                w.us_o  = !w.wet ? 24'd0 :
                          (w.lin ? w.us_lin : (w.u_sat ? WORD_MAX : w.u_q));
            end

            stg_next[gi] = w;
            vld_next[gi] = vld_reg[gi-1];
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_STAGES; i++)
            stg_reg[i] <= stg_next[i];
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // Result ports
    assign done                   = vld_reg[NUM_STAGES-1];
    assign result.effective_depth = stg_reg[NUM_STAGES-1].h;
    assign result.velocity        = stg_reg[NUM_STAGES-1].vel_o;
    assign result.froude_number   = stg_reg[NUM_STAGES-1].fr_o;
    assign result.shear_velocity  = stg_reg[NUM_STAGES-1].us_o;

endmodule

// ===== tb/tb_node_hydraulic_quantities_core.sv =====
`timescale 1ns / 100ps

module tb_node_hydraulic_quantities_core;
    import nhq_pkg::*;

    localparam int FRAC = 16;
    localparam int TAIL_CYCLES = 120;

    // Expected node results, worked out when a request is accepted
    class node_scoreboard;
        logic [15:0] ice_sg;
        logic [23:0] min_depth;
        out_t pending[$];

        function new();
            ice_sg = ICE_SG_RESET;
            min_depth = MIN_DEPTH_RESET;
        endfunction

        static function longint unsigned int_sqrt(longint unsigned x);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x)
                b >>= 2;
            while (b != 0)
            begin
                if (x >= r + b)
                begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        // log2 in Q20, by repeated squaring of the normalized mantissa
        static function longint unsigned log2_fix(longint unsigned x);
            int k;
            longint unsigned y;
            longint unsigned res;
            k = 0;
            while (k < 63 && (x >> (k + 1)) != 0)
                k++;
            y = (k >= 30) ? (x >> (k - 30)) : (x << (30 - k));
            res = longint'(k) << 20;
            for (int i = 0; i < 20; i++)
            begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30))
                begin
                    y >>= 1;
                    res |= 64'd1 << (19 - i);
                end
            end
            return res;
        endfunction

        static function longint unsigned clamp24(longint unsigned v);
            return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
        endfunction

        function void note_request(in_t req);
            out_t e;
            longint unsigned ice, hu, ax, ay, mag, vel, fr, us, gh, root, b, den, t;
            longint h, l, qx, qy;
            vel = 0;
            fr = 0;
            us = 0;
            qx = longint'(req.discharge_x);
            qy = longint'(req.discharge_y);
            ice = (longint'(ice_sg) * longint'(req.ice_thickness) + 32768) >> 16;
            h = longint'(req.water_depth) - longint'(ice);
            if (h > longint'(min_depth))
            begin
                hu = h;
                ax = (qx < 0) ? -qx : qx;
                ay = (qy < 0) ? -qy : qy;
                mag = int_sqrt(ax * ax + ay * ay);
                vel = clamp24((mag << FRAC) / hu);
                gh = 642646 * hu;
                root = int_sqrt(gh);
                fr = (root == 0) ? 64'hFFFFFF : clamp24((vel << FRAC) / root);
                if (12000 * hu > 2718 * longint'(req.bed_roughness))
                begin
                    b = (req.bed_roughness == 0) ? 1 : req.bed_roughness;
                    l = longint'(log2_fix(12 * hu)) - longint'(log2_fix(b));
                    den = 0;
                    if (l > 0)
                        den = (longint'(l) * 1817043 + (64'd1 << 19)) >> 20;
                    us = (den == 0) ? 64'hFFFFFF : clamp24((vel << 20) / den);
                end
                else
                begin
                    t = ((2718 * longint'(req.bed_roughness)) << 16) / (30000 * hu);
                    if (vel != 0 && t > 64'hFFFF_FFFF_FFFF_FFFF / vel)
                        us = 64'hFFFFFF;
                    else
                        us = clamp24((vel * t) >> 16);
                end
            end
            e.effective_depth = h[24:0];
            e.velocity = vel[23:0];
            e.froude_number = fr[23:0];
            e.shear_velocity = us[23:0];
            pending.push_back(e);
        endfunction

        // Returns a description of the first problem, empty when the result matches
        function string check_result(out_t got);
            out_t e;
            if (pending.size() == 0)
                return $sformatf("unexpected result %h", got);
            e = pending.pop_front();
            if (got.effective_depth !== e.effective_depth)
                return $sformatf("effective_depth %h, expected %h",
                                 got.effective_depth, e.effective_depth);
            if (got.velocity !== e.velocity)
                return $sformatf("velocity %h, expected %h", got.velocity, e.velocity);
            if (got.froude_number !== e.froude_number)
                return $sformatf("froude_number %h, expected %h",
                                 got.froude_number, e.froude_number);
            if (got.shear_velocity !== e.shear_velocity)
                return $sformatf("shear_velocity %h, expected %h",
                                 got.shear_velocity, e.shear_velocity);
            return "";
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    in_t request = '0;
    logic done;
    out_t result;

    node_scoreboard nodes = new();
    int errors = 0;
    int idle_pct = 0;

    node_hydraulic_quantities_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .request(request),
        .done(done), .result(result)
    );

    always #1 clk = ~clk;

    task automatic report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        string msg;
        if (rst_n && done)
        begin
            msg = nodes.check_result(result);
            if (msg != "")
                report(msg);
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ICE_SG)
            nodes.ice_sg = value[15:0];
        else
            nodes.min_depth = value[23:0];
    endtask

    // Sends one request; each cycle before it is idle with chance idle_pct
    task automatic send_node(in_t req);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        request <= req;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        nodes.note_request(req);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (nodes.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_bits();
        return 24'($urandom & ((32'd1 << $urandom_range(1, 24)) - 1));
    endfunction

    function automatic in_t make_node(logic [23:0] d, logic [23:0] qx, logic [23:0] qy,
                                      logic [23:0] ti, logic [23:0] ks);
        in_t r;
        r.water_depth = d;
        r.discharge_x = qx;
        r.discharge_y = qy;
        r.ice_thickness = ti;
        r.bed_roughness = ks;
        return r;
    endfunction

    // Random node: mostly wet with plausible roughness, some raw noise
    function automatic in_t random_node();
        in_t r;
        r = make_node(rand_bits(), rand_bits(), rand_bits(), rand_bits(), rand_bits());
        if ($urandom_range(3) != 0)
        begin
            r.water_depth = 24'($urandom_range(24'hFFFFFF, 700));
            r.ice_thickness = ($urandom_range(2) == 0) ? rand_bits() : 24'd0;
            if ($urandom_range(1))
                r.discharge_x = -r.discharge_x;
            if ($urandom_range(4) == 0)
                r.bed_roughness = 24'd0;
        end
        return r;
    endfunction

    task automatic random_phase(int count, int pct);
        idle_pct = pct;
        repeat (count) send_node(random_node());
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed nodes at reset settings
        send_node(make_node(24'd0, 24'd0, 24'd0, 24'd0, 24'd0));
        send_node(make_node(24'hFFFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'd0, 24'hFFFFFF));
        send_node(make_node(24'hFFFFFF, 24'h800000, 24'h800000, 24'd0, 24'd1));
        send_node(make_node(24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'd0, 24'd0));
        send_node(make_node(24'd655, 24'h10000, 24'h10000, 24'd0, 24'd100));
        send_node(make_node(24'd656, 24'h7FFFFF, 24'h800000, 24'd0, 24'd100));
        send_node(make_node(24'd656, 24'h7FFFFF, 24'd0, 24'd0, 24'd0));
        send_node(make_node(24'd2718, 24'h10000, 24'd0, 24'd0, 24'd12000));
        send_node(make_node(24'd2719, 24'h10000, 24'd0, 24'd0, 24'd12000));
        send_node(make_node(24'h20000, 24'h8000, 24'h3000, 24'd0, 24'hFFFFFF));
        send_node(make_node(24'h20000, 24'hFF8000, 24'h3000, 24'd32768, 24'h1000));
        send_node(make_node(24'h10000, 24'h1000, 24'h1000, 24'hFFFFFF, 24'h1000));
        send_node(make_node(24'h50000, 24'h30000, 24'hFD0000, 24'h10000, 24'h200));
        send_node(make_node(24'h10000, 24'd0, 24'd0, 24'd0, 24'h10000));
        drain();

        random_phase(400, 0);

        write_reg(REG_ICE_SG, 32'hFFFFFFFF);
        write_reg(REG_MIN_DEPTH, 32'd0);
        send_node(make_node(24'd1, 24'h7FFFFF, 24'h7FFFFF, 24'd0, 24'd0));
        send_node(make_node(24'd2, 24'h800000, 24'd5, 24'd1, 24'hFFFFFF));
        random_phase(400, 48);

        write_reg(REG_ICE_SG, 32'd0);
        write_reg(REG_MIN_DEPTH, 32'h00FFFFFF);
        random_phase(100, 20);

        write_reg(REG_ICE_SG, {16'hA5A5, 16'($urandom)});
        write_reg(REG_MIN_DEPTH, {8'h5A, 24'($urandom_range(20000))});
        random_phase(400, 20);

        write_reg(REG_ICE_SG, 32'(ICE_SG_RESET));
        write_reg(REG_MIN_DEPTH, 32'(MIN_DEPTH_RESET));
        random_phase(350, 48);

        if (errors == 0)
            $display("node_hydraulic_quantities_core regression: pass");
        else
            $display("node_hydraulic_quantities_core regression: fail");
        $finish;
    end

    initial
    begin
        #400000;
        $display("node_hydraulic_quantities_core regression: fail");
        $finish;
    end

endmodule
